// File: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam logic [3:0] OP_TEXT    = 4'h1;
  localparam logic [3:0] OP_CLOSE   = 4'h8;
  localparam logic [6:0] LEN_EXT64  = 7'd127;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] EXT16_BYTES = 4'd2;

  localparam logic [1:0] KIND_PAYLOAD     = 2'd0;
  localparam logic [1:0] KIND_EMPTY       = 2'd1;
  localparam logic [1:0] KIND_CLOSE       = 2'd2;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_frame;
  } out_t;

  // one result from the parser toward the output register
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

endpackage

// File: rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decode, length and key capture, payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  wsd_pkg::in_t item,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR1    = 6'b000001,
    PH_HDR2    = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             ext_bytes_left, ext_bytes_left_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [3:0][7:0]        mask_key, mask_key_next;
  logic                   mask_on, mask_on_next;
  logic [1:0]             key_index, key_index_next;

  logic [7:0]             b;
  logic [3:0]             ext_dec;
  logic [LENGTH_BITS-1:0] len_shift;
  logic                   hdr_done;
  logic                   hdr_mask;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic                   rem_last;

  assign b         = item.byte_in;
  assign ext_dec   = (ext_bytes_left != '0) ? ext_bytes_left - 4'd1 : ext_bytes_left;
  assign len_shift = {bytes_remaining[LENGTH_BITS-9:0], b};
  assign rem_last  = (bytes_remaining[LENGTH_BITS-1:1] == '0);

  always_comb begin
    phase_next           = phase;
    ext_bytes_left_next  = ext_bytes_left;
    bytes_remaining_next = bytes_remaining;
    mask_key_next        = mask_key;
    mask_on_next         = mask_on;
    key_index_next       = key_index;
    hdr_done             = 1'b0;
    hdr_mask             = mask_on;
    hdr_len              = bytes_remaining;
    res                  = '0;

    case (phase)
      PH_HDR1: begin
        if (b[3:0] == OP_CLOSE) begin
          phase_next = PH_HALT;
          res.valid  = 1'b1;
          res.item.kind = KIND_CLOSE;
          res.item.last_of_frame = 1'b1;
        end else if (b[3:0] != OP_TEXT) begin
          phase_next = PH_HALT;
          res.valid  = 1'b1;
          res.item.kind = KIND_UNSUPPORTED;
          res.item.last_of_frame = 1'b1;
        end else begin
          phase_next = PH_HDR2;
        end
      end
      PH_HDR2: begin
        mask_on_next = b[7];
        hdr_mask     = b[7];
        if (b[6:0] == LEN_EXT64) begin
          bytes_remaining_next = '0;
          ext_bytes_left_next  = EXT64_BYTES;
          phase_next           = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT16) begin
          bytes_remaining_next = '0;
          ext_bytes_left_next  = EXT16_BYTES;
          phase_next           = PH_EXTLEN;
        end else begin
          bytes_remaining_next = LENGTH_BITS'(b[6:0]);
          hdr_len              = LENGTH_BITS'(b[6:0]);
          hdr_done             = 1'b1;
        end
      end
      PH_EXTLEN: begin
        bytes_remaining_next = len_shift;
        hdr_len              = len_shift;
        ext_bytes_left_next  = ext_dec;
        hdr_done             = (ext_dec == '0);
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[2:0], b};
        key_index_next = key_index + 2'd1;
        if (key_index == 2'd3) begin
          key_index_next = '0;
          if (bytes_remaining == '0) begin
            phase_next = PH_HDR1;
            res.valid  = 1'b1;
            res.item.kind = KIND_EMPTY;
            res.item.last_of_frame = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        key_index_next = key_index + 2'd1;
        // key byte 0 sits in the top byte, so select with the inverted index
        res.valid      = 1'b1;
        res.item.kind  = KIND_PAYLOAD;
        res.item.data_byte = mask_on ? (b ^ mask_key[~key_index]) : b;
        if (bytes_remaining != '0) begin
          bytes_remaining_next = bytes_remaining - LENGTH_BITS'(1);
        end
        if (rem_last) begin
          phase_next = PH_HDR1;
          res.item.last_of_frame = 1'b1;
        end
      end
      default: begin
        // halted: drop stream bytes until restart
      end
    endcase

    if (hdr_done) begin
      key_index_next = '0;
      if (hdr_mask) begin
        phase_next    = PH_KEY;
        mask_key_next = '0;
      end else if (hdr_len == '0) begin
        phase_next = PH_HDR1;
        res.valid  = 1'b1;
        res.item.kind = KIND_EMPTY;
        res.item.last_of_frame = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    if (item.restart) begin
      phase_next           = PH_HDR1;
      ext_bytes_left_next  = '0;
      bytes_remaining_next = '0;
      mask_key_next        = '0;
      mask_on_next         = 1'b0;
      key_index_next       = '0;
      res                  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR1;
      ext_bytes_left  <= '0;
      bytes_remaining <= '0;
      mask_key        <= '0;
      mask_on         <= 1'b0;
      key_index       <= '0;
    end else if (take) begin
      phase           <= phase_next;
      ext_bytes_left  <= ext_bytes_left_next;
      bytes_remaining <= bytes_remaining_next;
      mask_key        <= mask_key_next;
      mask_on         <= mask_on_next;
      key_index       <= key_index_next;
    end
  end

endmodule

// File: rtl/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  wsd_pkg::res_t res,
  output logic          valid,
  input  logic          stall,
  output wsd_pkg::out_t item
);
  import wsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= res.valid;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      item <= res.item;
    end
  end

endmodule

// File: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a received frame stream byte by byte and delivers unmasked payload.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  stream   | in        | stream_valid / stream_stall  | in_t  (byte_in, restart)
//  result   | out       | result_valid / result_stall  | out_t (kind, data_byte, last)
//
// One byte per clock when not stalled: the parser state updates at the request's
// accept edge and the result, if any, shows in the result register on the next cycle.
// Unless stalled, the single state update loop sets the rate: one request a cycle.
// rst is synchronous; it returns the parser to frame start, result empty.
// A stalled result stalls the stream only while the result register is full.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          stream_valid,
  output logic          stream_stall,
  input  wsd_pkg::in_t  stream,
  output logic          result_valid,
  input  logic          result_stall,
  output wsd_pkg::out_t result
);
  import wsd_pkg::*;

  logic take;
  res_t res;

  assign stream_stall = result_valid && result_stall;
  assign take         = stream_valid && !stream_stall;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (stream),
    .res  (res)
  );

  wsd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (take),
    .res   (res),
    .valid (result_valid),
    .stall (result_stall),
    .item  (result)
  );

  // events always close the frame
  a_event_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind != KIND_PAYLOAD) |-> result.last_of_frame)
    else $error("event without last_of_frame");

  a_event_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind != KIND_PAYLOAD) |-> (result.data_byte == 8'h00))
    else $error("event with nonzero data");

  // a restart request never leaves a result behind
  a_restart_empty: assert property (@(posedge clk) disable iff (rst)
    take && stream.restart |=> !result_valid)
    else $error("result after restart");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    stream_stall |-> result_valid)
    else $error("stream stalled with empty result register");

endmodule
